FILE: rtl/kplt_pkg.sv
// Package for the keyed point list table.
// Holds table sizes, operation and status codes, and the result struct.
// No dependencies.
package kplt_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int MAX_POINTS = 16;

    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int POINT_W = $clog2(MAX_POINTS);
    localparam int USED_W  = $clog2(MAX_SLOTS + 1);
    localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PADDR_W = SLOT_W + POINT_W;

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int ID_W   = 32;
    localparam int OFFS_W = 32;
    localparam int VAL_W  = 64;

    localparam logic [OP_W-1:0] OP_ADD_KEY   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_POINT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE      = 2'd3;

    localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_SLOTS);
    localparam logic [PCNT_W-1:0] PCNT_MAX = PCNT_W'(MAX_POINTS);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [SLOT_W-1:0]        slot_out;
        logic [POINT_W-1:0]       point_out;
        logic signed [OFFS_W-1:0] offset_out;
        logic [VAL_W-1:0]         value_out;
        logic [ID_W-1:0]          slot_id;
        logic [USED_W-1:0]        used_slots;
        logic [PCNT_W-1:0]        slot_points;
    } rsp_t;

endpackage

FILE: rtl/kplt_if.sv
// Valid/ready channel interfaces for the keyed point list table.
// Request channel carries one operation item, response channel one result item.
// Depends on kplt_pkg.
interface kplt_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [kplt_pkg::OP_W-1:0]             operation;
    logic [kplt_pkg::ID_W-1:0]             param_id;
    logic [kplt_pkg::SLOT_W-1:0]           slot_index;
    logic [kplt_pkg::POINT_W-1:0]          point_index;
    logic signed [kplt_pkg::OFFS_W-1:0]    sample_offset;
    logic [kplt_pkg::VAL_W-1:0]            value;

    modport source (output valid, operation, param_id, slot_index, point_index,
                    sample_offset, value, input ready);
    modport sink   (input valid, operation, param_id, slot_index, point_index,
                    sample_offset, value, output ready);
endinterface

interface kplt_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [kplt_pkg::STAT_W-1:0]           status;
    logic [kplt_pkg::SLOT_W-1:0]           slot_out;
    logic [kplt_pkg::POINT_W-1:0]          point_out;
    logic signed [kplt_pkg::OFFS_W-1:0]    offset_out;
    logic [kplt_pkg::VAL_W-1:0]            value_out;
    logic [kplt_pkg::ID_W-1:0]             slot_id;
    logic [kplt_pkg::USED_W-1:0]           used_slots;
    logic [kplt_pkg::PCNT_W-1:0]           slot_points;

    modport source (output valid, status, slot_out, point_out, offset_out, value_out,
                    slot_id, used_slots, slot_points, input ready);
    modport sink   (input valid, status, slot_out, point_out, offset_out, value_out,
                    slot_id, used_slots, slot_points, output ready);
endinterface

FILE: rtl/keyed_point_list_table.sv
// Keyed point list table: top level with key scan sequencer and table memories.
// Depends on kplt_pkg and the channel interfaces in kplt_if.sv.
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  ---------------------------------------------------
//  req      in   valid/ready   operation, param_id, slot_index, point_index,
//                              sample_offset, value
//  rsp      out  valid/ready   status, slot_out, point_out, offset_out, value_out,
//                              slot_id, used_slots, slot_points
//
// One item at a time; req.ready is high only while the sequencer idles.
// Clear or unused slot: S_HOLD to the result register. Add point, or read point past the
// list end: S_SLOT, then S_HOLD. Read point: S_SLOT, S_PT, S_HOLD. Add key: S_SCAN, one
// slot per cycle via the key memory read port up to a hit or the last slot, then S_HOLD.
// Reset clears the state, the output valid and the slot count; memories need no clearing pass.
// A new item is taken while the previous result waits; the next one holds until rsp is free.
module keyed_point_list_table (
    input  logic       clk,
    input  logic       rst_n,
    kplt_req_if.sink   req,
    kplt_rsp_if.source rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SLOT = 3'd2;
    localparam logic [2:0] S_PT   = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    localparam int SLOT_W  = kplt_pkg::SLOT_W;
    localparam int POINT_W = kplt_pkg::POINT_W;
    localparam int USED_W  = kplt_pkg::USED_W;
    localparam int PCNT_W  = kplt_pkg::PCNT_W;
    localparam int PADDR_W = kplt_pkg::PADDR_W;
    localparam int PDEPTH  = kplt_pkg::MAX_SLOTS * (2 ** POINT_W);

    logic [2:0]                  state_reg, state_next;
    logic [USED_W-1:0]           used_reg, used_next;
    logic                        out_valid_reg, out_valid_next;

    logic [kplt_pkg::OP_W-1:0]   op_reg, op_next;
    logic [kplt_pkg::ID_W-1:0]   id_reg, id_next;
    logic [SLOT_W-1:0]           sidx_reg, sidx_next;
    logic [POINT_W-1:0]          pidx_reg, pidx_next;
    logic [kplt_pkg::OFFS_W-1:0] offs_reg, offs_next;
    logic [kplt_pkg::VAL_W-1:0]  val_reg, val_next;
    logic [SLOT_W-1:0]           idx_reg, idx_next;
    kplt_pkg::rsp_t              res_reg, res_next;
    kplt_pkg::rsp_t              out_reg, out_next;

    logic [kplt_pkg::ID_W-1:0]   key_mem [kplt_pkg::MAX_SLOTS];
    logic [PCNT_W-1:0]           cnt_mem [kplt_pkg::MAX_SLOTS];
    logic [kplt_pkg::OFFS_W-1:0] off_mem [PDEPTH];
    logic [kplt_pkg::VAL_W-1:0]  pval_mem [PDEPTH];

    logic [SLOT_W-1:0]           raddr;
    logic [kplt_pkg::ID_W-1:0]   key_rd_reg;
    logic [PCNT_W-1:0]           cnt_rd_reg;
    logic [PADDR_W-1:0]          pt_raddr;
    logic [kplt_pkg::OFFS_W-1:0] off_rd_reg;
    logic [kplt_pkg::VAL_W-1:0]  pval_rd_reg;

    logic                        key_we;
    logic [SLOT_W-1:0]           key_waddr;
    logic                        cnt_we;
    logic [SLOT_W-1:0]           cnt_waddr;
    logic [PCNT_W-1:0]           cnt_wdata;
    logic                        pt_we;
    logic [PADDR_W-1:0]          pt_waddr;

    logic                        key_match;
    logic                        scan_last;

    assign req.ready = (state_reg == S_IDLE);
    assign pt_raddr  = {sidx_reg, pidx_reg};

    // shared comparator of the key scan
    assign key_match = (key_rd_reg == id_reg);
    assign scan_last = ((USED_W'(idx_reg) + USED_W'(1)) == used_reg);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_next        = op_reg;
        id_next        = id_reg;
        sidx_next      = sidx_reg;
        pidx_next      = pidx_reg;
        offs_next      = offs_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        raddr          = idx_reg + SLOT_W'(1);
        key_we         = 1'b0;
        key_waddr      = used_reg[SLOT_W-1:0];
        cnt_we         = 1'b0;
        cnt_waddr      = used_reg[SLOT_W-1:0];
        cnt_wdata      = '0;
        pt_we          = 1'b0;
        pt_waddr       = {sidx_reg, cnt_rd_reg[POINT_W-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                raddr = (req.operation == kplt_pkg::OP_ADD_KEY) ? '0 : req.slot_index;
                if (req.valid)
                begin
                    op_next    = req.operation;
                    id_next    = req.param_id;
                    sidx_next  = req.slot_index;
                    pidx_next  = req.point_index;
                    offs_next  = req.sample_offset;
                    val_next   = req.value;
                    idx_next   = '0;
                    res_next   = '0;
                    res_next.used_slots = used_reg;
                    state_next = S_HOLD;
                    case (req.operation)
                        kplt_pkg::OP_ADD_KEY:
                        begin
                            if (used_reg == '0)
                            begin
                                // empty table: allocate slot 0 at once
                                key_we    = 1'b1;
                                cnt_we    = 1'b1;
                                used_next = USED_W'(1);
                                res_next.slot_id    = req.param_id;
                                res_next.used_slots = USED_W'(1);
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        kplt_pkg::OP_ADD_POINT, kplt_pkg::OP_READ:
                        begin
                            if (USED_W'(req.slot_index) >= used_reg)
                                res_next.status = kplt_pkg::ST_RANGE;
                            else
                                state_next = S_SLOT;
                        end
                        default:
                        begin
                            used_next           = '0;
                            res_next.used_slots = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (key_match)
                begin
                    res_next.slot_out    = idx_reg;
                    res_next.slot_id     = id_reg;
                    res_next.slot_points = cnt_rd_reg;
                    state_next           = S_HOLD;
                end
                else if (scan_last)
                begin
                    if (used_reg == kplt_pkg::USED_MAX)
                    begin
                        res_next.status = kplt_pkg::ST_TABLE_FULL;
                    end
                    else
                    begin
                        key_we    = 1'b1;
                        cnt_we    = 1'b1;
                        used_next = used_reg + USED_W'(1);
                        res_next.slot_out   = used_reg[SLOT_W-1:0];
                        res_next.slot_id    = id_reg;
                        res_next.used_slots = used_reg + USED_W'(1);
                    end
                    state_next = S_HOLD;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_SLOT:
            begin
                res_next.slot_id     = key_rd_reg;
                res_next.slot_points = cnt_rd_reg;
                state_next           = S_HOLD;
                if (op_reg == kplt_pkg::OP_ADD_POINT)
                begin
                    if (cnt_rd_reg >= kplt_pkg::PCNT_MAX)
                    begin
                        res_next.status = kplt_pkg::ST_LIST_FULL;
                    end
                    else
                    begin
                        pt_we     = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_waddr = sidx_reg;
                        cnt_wdata = cnt_rd_reg + PCNT_W'(1);
                        res_next.point_out   = cnt_rd_reg[POINT_W-1:0];
                        res_next.slot_points = cnt_rd_reg + PCNT_W'(1);
                    end
                end
                else if (PCNT_W'(pidx_reg) >= cnt_rd_reg)
                begin
                    res_next.status = kplt_pkg::ST_RANGE;
                end
                else
                begin
                    state_next = S_PT;
                end
            end
            S_PT:
            begin
                res_next.offset_out = off_rd_reg;
                res_next.value_out  = pval_rd_reg;
                state_next          = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        id_reg   <= id_next;
        sidx_reg <= sidx_next;
        pidx_reg <= pidx_next;
        offs_reg <= offs_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // slot memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= id_next;
        key_rd_reg <= key_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[raddr];
    end

    // point memories, addressed by slot and position
    always_ff @(posedge clk)
    begin
        if (pt_we)
            off_mem[pt_waddr] <= offs_reg;
        off_rd_reg <= off_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pval_mem[pt_waddr] <= val_reg;
        pval_rd_reg <= pval_mem[pt_raddr];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.slot_out    = out_reg.slot_out;
    assign rsp.point_out   = out_reg.point_out;
    assign rsp.offset_out  = out_reg.offset_out;
    assign rsp.value_out   = out_reg.value_out;
    assign rsp.slot_id     = out_reg.slot_id;
    assign rsp.used_slots  = out_reg.used_slots;
    assign rsp.slot_points = out_reg.slot_points;

endmodule

FILE: rtl/kplt_checker.sv
// Port-level checker for the keyed point list table, with its bind statement.
// Depends on kplt_pkg and the top level's request and response channels.
module kplt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_ready,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [kplt_pkg::STAT_W-1:0]       rsp_status,
    input  logic [kplt_pkg::SLOT_W-1:0]       rsp_slot_out,
    input  logic [kplt_pkg::ID_W-1:0]         rsp_slot_id,
    input  logic [kplt_pkg::USED_W-1:0]       rsp_used_slots,
    input  logic [kplt_pkg::PCNT_W-1:0]       rsp_slot_points
);

    // result item stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot_id) && $stable(rsp_used_slots))
        else $error("rsp item dropped or changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while an item is in work");

    // table full only with every slot taken, and addresses nothing
    a_table_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == kplt_pkg::ST_TABLE_FULL) |->
            (rsp_used_slots == kplt_pkg::USED_MAX) && (rsp_slot_id == '0)
            && (rsp_slot_points == '0) && (rsp_slot_out == '0))
        else $error("table full result inconsistent");

    // counts never pass the table bounds
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_used_slots <= kplt_pkg::USED_MAX)
            && (rsp_slot_points <= kplt_pkg::PCNT_MAX))
        else $error("slot or point count beyond capacity");

endmodule

bind keyed_point_list_table kplt_checker u_kplt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_slot_out    (rsp.slot_out),
    .rsp_slot_id     (rsp.slot_id),
    .rsp_used_slots  (rsp.used_slots),
    .rsp_slot_points (rsp.slot_points)
);
